// ----- src/rational_arithmetic_unit_defines.svh -----
// Assertion macros for the rational arithmetic unit.
// Depends on nothing; included by modules that assert.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define RAU_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define RAU_ASSERT(lbl, clk, rstn, prop)
`define RAU_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- src/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ProdWidth = 2 * OperandWidth;
  localparam int unsigned MagWidth = ProdWidth + 1;
  localparam int unsigned StepWidth = $clog2(MagWidth + 1);

  typedef enum logic [2:0] {
    FuncAdd = 3'd0, FuncSub = 3'd1, FuncMul = 3'd2, FuncDiv = 3'd3,
    FuncEq = 3'd4, FuncNe = 3'd5, FuncGt = 3'd6, FuncLt = 3'd7
  } func_e;

  typedef struct packed {
    logic                  err;
    logic                  is_cmp;
    logic [2:0]            func;
    logic                  an_neg;
    logic [OperandWidth-1:0] an_mag;
    logic [OperandWidth-1:0] ad_mag;
    logic                  bn_neg;
    logic [OperandWidth-1:0] bn_mag;
    logic [OperandWidth-1:0] bd_mag;
  } item_t;
endpackage

// ----- src/rau_front.sv -----
// Front end: accept a word, classify it, fold signs into numerators.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; (
  input  logic                    start_i,
  input  logic                    full_i,
  input  logic [2:0]              func_i,
  input  logic [OperandWidth-1:0] a_num_i,
  input  logic [OperandWidth-1:0] a_den_i,
  input  logic [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-1:0] b_den_i,
  output logic                    push_o,
  output item_t                   item_o
);
  logic an_s, ad_s, bn_s, bd_s;
  logic [OperandWidth-1:0] an_m, ad_m, bn_m, bd_m;

  assign an_s = a_num_i[OperandWidth-1];
  assign ad_s = a_den_i[OperandWidth-1];
  assign bn_s = b_num_i[OperandWidth-1];
  assign bd_s = b_den_i[OperandWidth-1];
  assign an_m = an_s ? (~a_num_i + 1'b1) : a_num_i;
  assign ad_m = ad_s ? (~a_den_i + 1'b1) : a_den_i;
  assign bn_m = bn_s ? (~b_num_i + 1'b1) : b_num_i;
  assign bd_m = bd_s ? (~b_den_i + 1'b1) : b_den_i;

  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.func = func_i;
    item_o.is_cmp = func_i[2];
    item_o.err = (ad_m == '0) || (bd_m == '0) ||
                 ((func_i == FuncDiv) && (bn_m == '0));
    item_o.an_mag = an_m;
    item_o.ad_mag = ad_m;
    item_o.bn_mag = bn_m;
    item_o.bd_mag = bd_m;
    item_o.an_neg = (an_m != '0) && (an_s != ad_s);
    item_o.bn_neg = (bn_m != '0) && ((bn_s != bd_s) ^ (func_i == FuncSub));
  end
endmodule

// ----- src/rau_queue.sv -----
// Two-entry queue between front and back end.
// Depends on rau_pkg.
module rau_queue import rau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t data_o
);
  item_t mem_q [2];
  logic wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d = wp_q ^ push_i;
    rp_d = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign data_o = mem_q[rp_q];
  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
endmodule

// ----- src/rau_back.sv -----
// Back end: cross products, sum, binary gcd, two restoring divisions.
// Depends on rau_pkg and the assertion macros header.
`include "rational_arithmetic_unit_defines.svh"
module rau_back import rau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  item_t        item_i,
  output logic         pop_o,
  output logic         done_o,
  output logic [31:0]  res_num_o,
  output logic [30:0]  res_den_o,
  output logic         compare_true_o,
  output logic         status_o
);
  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StMul = 7'b0000010, StSum = 7'b0000100,
    StGcd = 7'b0001000, StDivN = 7'b0010000, StDivD = 7'b0100000,
    StOut = 7'b1000000
  } state_e;

  state_e st_q, st_d;
  item_t it_q;
  logic [MagWidth-1:0] p1_q, p2_q, den_q, num_q, gx_q, gy_q, g_q;
  logic [MagWidth-1:0] quo_q, rem_q, nres_q;
  logic num_neg_q;
  logic [StepWidth-1:0] sh_q, cnt_q;
  logic [31:0] rn_q;
  logic [30:0] rd_q;
  logic cmp_q, stat_q;

  assign pop_o = (st_q == StIdle) && !empty_i;

  // gcd step
  logic [MagWidth-1:0] gx_n, gy_n, diff;
  logic gx_ev, gy_ev;
  always_comb begin
    gx_ev = !gx_q[0];
    gy_ev = !gy_q[0];
    diff = (gx_q > gy_q) ? (gx_q - gy_q) : (gy_q - gx_q);
    gx_n = gx_q;
    gy_n = gy_q;
    if (gx_ev && gy_ev) begin
      gx_n = gx_q >> 1;
      gy_n = gy_q >> 1;
    end else if (gx_ev) begin
      gx_n = gx_q >> 1;
    end else if (gy_ev) begin
      gy_n = gy_q >> 1;
    end else begin
      gx_n = (gx_q < gy_q) ? gx_q : gy_q;
      gy_n = diff;
    end
  end

  // restoring division step
  logic [MagWidth:0] trial;
  logic [MagWidth-1:0] rem_sh;
  assign rem_sh = {rem_q[MagWidth-2:0], quo_q[MagWidth-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, g_q};

  logic [MagWidth-1:0] prod_a, prod_b, prod_c;
  assign prod_a = MagWidth'(it_q.an_mag) *
                  MagWidth'((it_q.func == FuncMul) ? it_q.bn_mag : it_q.bd_mag);
  assign prod_b = MagWidth'(it_q.bn_mag) * MagWidth'(it_q.ad_mag);
  assign prod_c = MagWidth'(it_q.ad_mag) *
                  MagWidth'((it_q.func == FuncDiv) ? it_q.bn_mag : it_q.bd_mag);

  logic s1, s2, sum_neg;
  logic [MagWidth-1:0] sum_mag;
  logic cmp_v;
  always_comb begin
    s1 = it_q.an_neg;
    s2 = it_q.bn_neg;
    sum_neg = s1;
    if (s1 == s2) begin
      sum_mag = p1_q + p2_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = s2;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
    unique case (it_q.func)
      FuncEq: cmp_v = (s1 == s2) && (p1_q == p2_q) || (p1_q == '0 && p2_q == '0);
      FuncNe: cmp_v = !((s1 == s2) && (p1_q == p2_q) || (p1_q == '0 && p2_q == '0));
      FuncGt: cmp_v = !s1 && s2 && (p1_q != '0 || p2_q != '0) ||
                      (!s1 && !s2 && p1_q > p2_q) || (s1 && s2 && p1_q < p2_q);
      FuncLt: cmp_v = s1 && !s2 && (p1_q != '0 || p2_q != '0) ||
                      (!s1 && !s2 && p1_q < p2_q) || (s1 && s2 && p1_q > p2_q);
      default: cmp_v = 1'b0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (!empty_i) st_d = StMul;
      StMul: st_d = it_q.err ? StOut : StSum;
      StSum: st_d = (it_q.is_cmp || sum_mag == '0 && it_q.func[1] == 1'b0 ||
                     it_q.func[1] && p1_q == '0) ? StOut : StGcd;
      StGcd: if (gx_q == gy_q) st_d = StDivN;
      StDivN: if (cnt_q == StepWidth'(MagWidth - 1)) st_d = StDivD;
      StDivD: if (cnt_q == StepWidth'(MagWidth - 1)) st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        it_q <= item_i;
        rn_q <= '0;
        rd_q <= 31'd1;
        cmp_q <= 1'b0;
        stat_q <= item_i.err;
      end
      StMul: begin
        p1_q <= prod_a;
        p2_q <= prod_b;
        den_q <= prod_c;
      end
      StSum: begin
        if (it_q.is_cmp) begin
          cmp_q <= cmp_v;
        end
        if (it_q.func[1]) begin
          num_q <= p1_q;
          num_neg_q <= (p1_q != '0) && (it_q.an_neg ^ it_q.bn_neg);
          gx_q <= p1_q;
        end else begin
          num_q <= sum_mag;
          num_neg_q <= sum_neg;
          gx_q <= sum_mag;
        end
        gy_q <= den_q;
        sh_q <= '0;
      end
      StGcd: begin
        if (gx_q == gy_q) begin
          g_q <= gx_q << sh_q;
          quo_q <= num_q;
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          gx_q <= gx_n;
          gy_q <= gy_n;
          if (gx_ev && gy_ev) sh_q <= sh_q + 1'b1;
        end
      end
      StDivN, StDivD: begin
        if (cnt_q == StepWidth'(MagWidth - 1)) begin
          cnt_q <= '0;
          rem_q <= '0;
          if (st_q == StDivN) begin
            nres_q <= {quo_q[MagWidth-2:0], !trial[MagWidth]};
            quo_q <= den_q;
          end else begin
            rn_q <= num_neg_q ? (~nres_q[31:0] + 1'b1) : nres_q[31:0];
            rd_q <= {quo_q[29:0], !trial[MagWidth]};
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (!trial[MagWidth]) begin
            rem_q <= trial[MagWidth-1:0];
            quo_q <= {quo_q[MagWidth-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[MagWidth-2:0], 1'b0};
          end
        end
      end
      StOut: ;
      default: ;
    endcase
  end

  assign done_o = st_q == StOut;
  assign res_num_o = rn_q;
  assign res_den_o = rd_q;
  assign compare_true_o = cmp_q;
  assign status_o = stat_q;

  `RAU_ASSERT(a_onehot, clk_i, rst_ni, $onehot(st_q))
  `RAU_ASSERT(a_pop_idle, clk_i, rst_ni, pop_o |=> st_q == StMul)
  `RAU_ASSERT(a_err_out, clk_i, rst_ni, done_o && status_o |-> res_den_o == 31'd1)
  `RAU_ASSERT(a_den_pos, clk_i, rst_ni, done_o |-> res_den_o != '0)
endmodule

// ----- src/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// channel  dir  handshake          word
// input    in   start_i && !busy_o func_i, a_num_i, a_den_i, b_num_i, b_den_i
// result   out  done_o (one cycle) res_num_o, res_den_o, compare_true_o, status_o
//
// From accept to result: errors, compares and zero results skip the gcd
// and the divisions; other arithmetic runs the binary gcd loop and then
// two 33-step restoring divisions.
// A two-word queue lets the front accept while the back works; busy_o is
// high when it is full. Reset is asynchronous and clears the control state.
// The receiver cannot stall; done_o flags each result for one cycle.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              func_i,
  input  logic [OperandWidth-1:0] a_num_i,
  input  logic [OperandWidth-1:0] a_den_i,
  input  logic [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-1:0] b_den_i,
  output logic                    done_o,
  output logic [31:0]             res_num_o,
  output logic [30:0]             res_den_o,
  output logic                    compare_true_o,
  output logic                    status_o
);
  item_t f_item, q_item;
  logic push, pop, full, empty;

  rau_front u_front (
    .start_i(start_i), .full_i(full), .func_i(func_i),
    .a_num_i(a_num_i), .a_den_i(a_den_i), .b_num_i(b_num_i), .b_den_i(b_den_i),
    .push_o(push), .item_o(f_item)
  );

  rau_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(f_item),
    .pop_i(pop), .full_o(full), .empty_o(empty), .data_o(q_item)
  );

  rau_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .empty_i(empty), .item_i(q_item),
    .pop_o(pop), .done_o(done_o), .res_num_o(res_num_o), .res_den_o(res_den_o),
    .compare_true_o(compare_true_o), .status_o(status_o)
  );

  assign busy_o = full;
endmodule
